@@ rtl/trwo_pkg.sv @@
// Package: shared constants, types and codes of the wavetable oscillator.
package trwo_pkg;

   localparam int unsigned SEGMENTS_DEF = 12;
   localparam logic [31:0] PHASE_STEP_RST = 32'd78738343;
   localparam logic [14:0] AMPLITUDE_RST = 15'd16384;
   localparam logic [10:0] STEP_COUNT_RST = 11'd1;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_TOUCH = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] ST_SAMPLE = 2'd0;
   localparam logic [1:0] ST_ABSORBED = 2'd1;
   localparam logic [1:0] ST_RECORDED = 2'd2;
   localparam logic [1:0] ST_MISFIRE = 2'd3;

   localparam logic [1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [1:0] CSR_AMPLITUDE = 2'd1;
   localparam logic [1:0] CSR_STEP_COUNT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK_MUL,
      S_TICK_K,
      S_TICK_PROD,
      S_TICK_DIV,
      S_TICK_AMP,
      S_MAX,
      S_ENTRY,
      S_ENTRY_DIV,
      S_ENTRY_WR,
      S_OUT
   } state_type;

   // Request to the shared divider.
   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/trwo_divider.sv @@
// Shared unsigned restoring divider, one quotient bit per cycle.
module trwo_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  trwo_pkg::div_req_type req,
   output trwo_pkg::div_rsp_type rsp
);
   import trwo_pkg::*;

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[31:0], quo_ff[47]};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

@@ rtl/touch_recorded_wavetable_oscillator.sv @@
// Top level: touch-recorded wavetable oscillator with sequencer and shared divider.
// A sample tick is dominated by one pass of the divider.
// A final release scans every pad for the longest hold and then, unless nothing was
// held, walks every entry through the divider.
// One item is in flight at a time; req_stall is high until its result beat leaves.
// Synchronous reset clears control state, the start times, table and phase at once.
module touch_recorded_wavetable_oscillator #(
   parameter int unsigned SEGMENTS = trwo_pkg::SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_pad,
   input  logic [31:0]        req_time_ms,
   input  logic               req_any_touch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic [1:0]         rsp_status,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import trwo_pkg::*;

   localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SEGMENTS - 1);

   state_type state_ff, state_in;

   logic [31:0] phase_step_ff;
   logic [14:0] amplitude_ff;
   logic [10:0] step_count_ff;

   logic        recording_ff, recording_in;
   logic [31:0] start_ff [SEGMENTS];
   logic signed [15:0] table_ff [SEGMENTS];
   logic [31:0] phase_ff, phase_in;

   logic [31:0] now_ff, now_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] fk_ff, fk_in;       // fraction, then k
   logic [10:0] s_ff, s_in;
   logic        neg_ff, neg_in;
   logic [47:0] mag_ff, mag_in;
   logic signed [16:0] v_ff, v_in;
   logic signed [15:0] smp_ff, smp_in;
   logic [1:0]  st_ff, st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        go_ff, go_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [63:0] pos;
   logic [IW-1:0] tidx, nidx;
   logic [42:0] ks;
   logic signed [16:0] diff;
   logic [31:0] dur;
   logic signed [32:0] vamp;
   logic signed [32:0] vflr;
   logic signed [17:0] ent;
   logic        accept;
   logic        tbl_we;
   logic signed [15:0] tbl_wd;
   logic        clr_starts;
   logic        st_we;

   trwo_divider u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   assign accept = req_valid && !req_stall;
   // The result registers are shared with the sequencer, so a waiting beat holds the input.
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = smp_ff;
   assign rsp_status = st_ff;

   always_comb begin
      pos = 64'(phase_ff) * 64'(SEGMENTS);
      tidx = IW'(pos[63:32]);
      if (pos[63:32] >= 32'(SEGMENTS)) tidx = LAST_IDX;
      nidx = (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
      ks = 43'(fk_ff) * 43'(s_ff);
      diff = 17'(table_ff[nidx]) - 17'(table_ff[idx_ff]);
      dur = (start_ff[idx_ff] == '0) ? '0 : now_ff - start_ff[idx_ff];
      vamp = 33'(v_ff) * $signed({18'd0, amplitude_ff});
      vflr = vamp >>> 15;
      ent = $signed({2'b00, div_rsp.quotient[15:0]}) - 18'sd32768;
      if (div_rsp.quotient[47:16] != '0) ent = 18'sd32767;
   end

   always_comb begin
      state_in = state_ff;
      recording_in = recording_ff;
      phase_in = phase_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      max_in = max_ff;
      fk_in = fk_ff;
      s_in = s_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      v_in = v_ff;
      smp_in = smp_ff;
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff;
      go_in = 1'b0;
      div_req = '0;
      tbl_we = 1'b0;
      tbl_wd = '0;
      clr_starts = 1'b0;
      st_we = 1'b0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in = req_time_ms;
               smp_in = '0;
               st_in = ST_ABSORBED;
               idx_in = '0;
               max_in = '0;
               case (req_opcode)
                  OP_TICK: state_in = S_TICK_MUL;
                  OP_TOUCH: begin
                     if (!recording_ff && req_any_touch) clr_starts = 1'b1;
                     st_we = 1'b1;
                     recording_in = req_any_touch;
                     state_in = S_OUT;
                  end
                  OP_RELEASE: begin
                     if (recording_ff && !req_any_touch) state_in = S_MAX;
                     else begin
                        recording_in = req_any_touch;
                        state_in = S_OUT;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_TICK_MUL: begin
            idx_in = tidx;
            fk_in = pos[31:0];
            s_in = (step_count_ff == '0) ? 11'd1 : step_count_ff;
            phase_in = phase_ff + phase_step_ff;
            state_in = S_TICK_K;
         end
         S_TICK_K: begin
            fk_in = 32'(ks[42:32]);
            state_in = S_TICK_PROD;
         end
         S_TICK_PROD: begin
            // k * |b - a|, divided by s, sign reapplied afterwards (truncation to zero).
            neg_in = diff[16];
            mag_in = 48'(fk_ff[10:0]) * 48'(diff[16] ? -diff : diff);
            go_in = 1'b1;
            state_in = S_TICK_DIV;
         end
         S_TICK_DIV: begin
            if (go_ff) begin
               div_req.start = 1'b1;
               div_req.dividend = mag_ff;
               div_req.divisor = 32'(s_ff);
            end
            if (div_rsp.done) begin
               v_in = 17'(table_ff[idx_ff]) + (neg_ff ? -$signed(div_rsp.quotient[16:0])
                                                      : $signed(div_rsp.quotient[16:0]));
               state_in = S_TICK_AMP;
            end
         end
         S_TICK_AMP: begin
            smp_in = 16'(vflr);
            st_in = ST_SAMPLE;
            state_in = S_OUT;
         end
         S_MAX: begin
            if (dur > max_ff) max_in = dur;
            idx_in = idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               if (dur == '0 && max_ff == '0) begin
                  st_in = ST_MISFIRE;
                  state_in = S_OUT;
               end else state_in = S_ENTRY;
            end
         end
         S_ENTRY: begin
            div_req.start = 1'b1;
            div_req.dividend = {dur, 16'd0};
            div_req.divisor = max_ff;
            state_in = S_ENTRY_DIV;
         end
         S_ENTRY_DIV: begin
            if (div_rsp.done) begin
               tbl_we = 1'b1;
               tbl_wd = 16'(ent);
               state_in = S_ENTRY_WR;
            end
         end
         S_ENTRY_WR: begin
            idx_in = idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               recording_in = 1'b0;
               st_in = ST_RECORDED;
               state_in = S_OUT;
            end else state_in = S_ENTRY;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         go_ff <= 1'b0;
         recording_ff <= 1'b0;
         phase_ff <= '0;
         phase_step_ff <= PHASE_STEP_RST;
         amplitude_ff <= AMPLITUDE_RST;
         step_count_ff <= STEP_COUNT_RST;
         for (int i = 0; i < SEGMENTS; i++) begin
            start_ff[i] <= '0;
            table_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         go_ff <= go_in;
         recording_ff <= recording_in;
         phase_ff <= phase_in;
         if (csr_write) begin
            case (csr_index)
               CSR_PHASE_STEP: phase_step_ff <= csr_data;
               CSR_AMPLITUDE: amplitude_ff <= csr_data[14:0];
               CSR_STEP_COUNT: step_count_ff <= csr_data[10:0];
               default: ;
            endcase
         end
         for (int i = 0; i < SEGMENTS; i++) begin
            if (st_we && 32'(req_pad) == 32'(i)) start_ff[i] <= req_time_ms;
            else if (clr_starts) start_ff[i] <= '0;
         end
         if (tbl_we) table_ff[idx_ff] <= tbl_wd;
      end
      now_ff <= now_in;
      idx_ff <= idx_in;
      max_ff <= max_in;
      fk_ff <= fk_in;
      s_ff <= s_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      v_ff <= v_in;
      smp_ff <= smp_in;
      st_ff <= st_in;
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_tick_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SAMPLE) |-> (rsp_sample == '0))
      else $error("non-zero sample on event result");
   a_record_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENTRY_WR && idx_ff == LAST_IDX) |=> !recording_ff)
      else $error("recording not left after table write");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");
endmodule

@@ tb/tb.sv @@
// Testbench for the touch-recorded wavetable oscillator, checked beat by beat against a predictor.
`timescale 1ns / 100ps

module tb;
   import trwo_pkg::*;

   localparam int NPADS = 12;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 800;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [1:0]         status;
   } osc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = OP_TICK;
   logic [3:0] req_pad = '0;
   logic [31:0] req_time_ms = '0;
   logic req_any_touch = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic [1:0] rsp_status;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Predictor state.
   logic [31:0] step_reg;
   logic [14:0] gain_reg;
   logic [10:0] levels_reg;
   logic gesture_open;
   logic [31:0] touch_start [NPADS];
   logic signed [15:0] wave [NPADS];
   logic [31:0] phase_acc;

   osc_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   logic [31:0] clock_ms = 32'd1000;

   touch_recorded_wavetable_oscillator uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

   task automatic report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Result checker.
   always @(posedge clock) begin
      osc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_sample !== want.sample)
               report($sformatf("sample %0d, expected %0d", rsp_sample, want.sample));
            if (rsp_status !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_status, want.status));
         end
      end
   end

   task automatic reset_model();
      step_reg = PHASE_STEP_RST;
      gain_reg = AMPLITUDE_RST;
      levels_reg = STEP_COUNT_RST;
      gesture_open = 1'b0;
      phase_acc = '0;
      for (int i = 0; i < NPADS; i++) begin
         touch_start[i] = '0;
         wave[i] = '0;
      end
   endtask

   function automatic logic signed [15:0] table_sample();
      logic [63:0] pos;
      logic [31:0] idx, nxt, frac, s;
      longint a, b, k, v, prod;
      pos = {32'b0, phase_acc} * 64'd12;
      idx = pos[63:32];
      frac = pos[31:0];
      if (idx >= NPADS) idx = NPADS - 1;
      nxt = (idx == NPADS - 1) ? 0 : idx + 1;
      s = (levels_reg == 0) ? 32'd1 : {21'b0, levels_reg};
      a = longint'(wave[idx]);
      b = longint'(wave[nxt]);
      k = longint'(({32'b0, frac} * {32'b0, s}) >> 32);
      v = a + (k * (b - a)) / longint'({32'b0, s});
      prod = v * longint'({17'b0, gain_reg});
      prod = prod >>> 15;
      return prod[15:0];
   endfunction

   // Turns hold times into table entries; returns 0 when nothing was held.
   function automatic bit build_table(input logic [31:0] now);
      logic [31:0] dur [NPADS];
      logic [31:0] longest;
      longint e;
      longest = '0;
      for (int i = 0; i < NPADS; i++) begin
         dur[i] = (touch_start[i] == 0) ? 32'd0 : now - touch_start[i];
         if (dur[i] > longest) longest = dur[i];
      end
      if (longest == 0) return 0;
      for (int i = 0; i < NPADS; i++) begin
         e = longint'(({32'b0, dur[i]} << 16) / {32'b0, longest}) - 32768;
         if (e > 32767) e = 32767;
         wave[i] = e[15:0];
      end
      return 1;
   endfunction

   task automatic predict_item(input logic [1:0] op, input logic [3:0] pad,
                               input logic [31:0] tm, input logic any);
      osc_result_type r;
      r.sample = '0;
      r.status = ST_ABSORBED;
      if (op == OP_TICK) begin
         r.sample = table_sample();
         phase_acc = phase_acc + step_reg;
         r.status = ST_SAMPLE;
      end else if (op == OP_TOUCH) begin
         if (!gesture_open && any)
            for (int i = 0; i < NPADS; i++) touch_start[i] = '0;
         if (pad < NPADS) touch_start[pad] = tm;
         gesture_open = any;
      end else if (op == OP_RELEASE) begin
         if (gesture_open && !any) begin
            if (build_table(tm)) begin
               r.status = ST_RECORDED;
               gesture_open = 1'b0;
            end else begin
               r.status = ST_MISFIRE;
            end
         end else begin
            gesture_open = any;
         end
      end
      pending_results.push_back(r);
   endtask

   task automatic send_item(input logic [1:0] op, input logic [3:0] pad,
                            input logic [31:0] tm, input logic any);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pad <= pad;
      req_time_ms <= tm;
      req_any_touch <= any;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(op, pad, tm, any);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PHASE_STEP: step_reg = value;
         CSR_AMPLITUDE: gain_reg = value[14:0];
         CSR_STEP_COUNT: levels_reg = value[10:0];
         default: ;
      endcase
   endtask

   task automatic tick(input int n);
      for (int i = 0; i < n; i++)
         send_item(OP_TICK, 4'($urandom), $urandom, 1'($urandom));
   endtask

   // One well-formed gesture: touches on random pads with occasional ticks, a release of all, then up to four ticks.
   task automatic gesture();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         clock_ms += $urandom_range(1, 3000);
         if (clock_ms == 0) clock_ms = 1;
         send_item(OP_TOUCH, 4'($urandom_range(0, 11)), clock_ms, 1'b1);
         if ($urandom_range(3) == 0) tick(1);
      end
      clock_ms += $urandom_range(0, 5000);
      send_item(OP_RELEASE, 4'($urandom), clock_ms, 1'b0);
      tick($urandom_range(0, 4));
   endtask

   task automatic noise_item();
      send_item(2'($urandom), 4'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic random_config();
      case ($urandom_range(3))
         0: write_reg(CSR_PHASE_STEP, 32'hFFFF_FFFF);
         1: write_reg(CSR_PHASE_STEP, $urandom_range(0, 1) ? 32'd0 : $urandom);
         default: write_reg(CSR_PHASE_STEP, $urandom_range(1000000, 400000000));
      endcase
      write_reg(CSR_AMPLITUDE, $urandom_range(0, 1) ? $urandom_range(0, 32767) : 32'd32767);
      case ($urandom_range(3))
         0: write_reg(CSR_STEP_COUNT, 32'd2047);
         1: write_reg(CSR_STEP_COUNT, 32'd0);
         default: write_reg(CSR_STEP_COUNT, $urandom_range(1, 2047));
      endcase
   endtask

   task automatic test_directed();
      tick(2);                                    // empty table gives silence
      send_item(OP_SPARE, 4'hF, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_RELEASE, 4'd0, 32'd5, 1'b0);   // release while not recording
      send_item(OP_TOUCH, 4'd0, 32'd0, 1'b1);     // touch at time zero reads untouched
      send_item(OP_TOUCH, 4'd15, 32'd40, 1'b1);   // pad beyond the table
      send_item(OP_RELEASE, 4'd3, 32'd90, 1'b0);  // nothing held: misfire
      send_item(OP_TOUCH, 4'd1, 32'hFFFF_FF00, 1'b1);
      send_item(OP_TOUCH, 4'd11, 32'hFFFF_FFF0, 1'b1);
      send_item(OP_TOUCH, 4'd12, 32'd7, 1'b1);
      send_item(OP_RELEASE, 4'd1, 32'h0000_0200, 1'b0); // hold times wrap
      write_reg(CSR_AMPLITUDE, 32'd32767);
      write_reg(CSR_STEP_COUNT, 32'd2047);
      write_reg(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);        // unmapped index is ignored
      tick(4);
      write_reg(CSR_STEP_COUNT, 32'd0);
      write_reg(CSR_PHASE_STEP, 32'h1555_5555);
      tick(4);
      write_reg(CSR_AMPLITUDE, 32'd0);
      tick(2);
   endtask

   task automatic test_random(input int sidle, input int ridle, input int items);
      int start_count;
      wait_idle();
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      random_config();
      start_count = 0;
      while (start_count < items) begin
         if ($urandom_range(9) < 7) begin
            gesture();
            start_count += 8;
         end else begin
            noise_item();
            start_count++;
         end
      end
   endtask

   // The receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         tick(12);
      join
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(34, 87, 260);
      test_random(87, 34, 260);
      test_random(0, 0, 260);
      test_backpressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
